FILE: rtl/qenc_pkg.sv
// shared types and constants for the multi-channel quadrature counter
package qenc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int COUNT_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_INIT   = 2'd1,
    KIND_PRESET = 2'd2
  } kind_t;

  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;

  // per-channel state kept in the state memory
  typedef struct packed {
    logic [1:0]         phase;
    logic [COUNT_W-1:0] count;
  } chan_state_t;

  // update decided for one word
  typedef struct packed {
    logic              we;
    chan_state_t       state;
    logic [COUNT_W-1:0] position;
    logic signed [1:0] dir;
  } step_t;

  // gray-order phase code: 00->0, 01->1, 11->2, 10->3
  function automatic logic [1:0] phase_of_pins(input logic a, input logic b);
    return {a, a ^ b};
  endfunction

endpackage

FILE: rtl/qenc_state_mem.sv
// channel state memory with registered read, write forwarding and reset valid bits
module qenc_state_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  qenc_pkg::addr_t            rd_addr,
  output qenc_pkg::chan_state_t      rd_data,
  input  logic                       wr_en,
  input  qenc_pkg::addr_t            wr_addr,
  input  qenc_pkg::chan_state_t      wr_data
);

  qenc_pkg::chan_state_t mem [qenc_pkg::NUM_CHANNELS];
  logic [qenc_pkg::NUM_CHANNELS-1:0] vld;
  qenc_pkg::chan_state_t rd_q;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // a write at the same edge as the read to that entry is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr] | (wr_en && (wr_addr == rd_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

  // never-written entries read as the reset state
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: rtl/qenc_step.sv
// x4 quadrature decode and count update for one word
module qenc_step (
  input  logic [1:0]                  kind,
  input  logic                        chan_ok,
  input  logic [1:0]                  pins,
  input  logic [qenc_pkg::COUNT_W-1:0] preset,
  input  qenc_pkg::chan_state_t       cur,
  output qenc_pkg::step_t             res
);

  logic [1:0] fwd_phase;
  logic [1:0] rev_phase;

  assign fwd_phase = cur.phase + 2'd1;
  assign rev_phase = cur.phase - 2'd1;

  always_comb begin
    res.we    = chan_ok;
    res.state = cur;
    res.dir   = qenc_pkg::DIR_NONE;
    case (qenc_pkg::kind_t'(kind))
      qenc_pkg::KIND_SAMPLE: begin
        if (pins == fwd_phase) begin
          res.state.phase = pins;
          res.state.count = cur.count + qenc_pkg::COUNT_W'(1);
          res.dir         = qenc_pkg::DIR_FWD;
        end else if (pins == rev_phase) begin
          res.state.phase = pins;
          res.state.count = cur.count - qenc_pkg::COUNT_W'(1);
          res.dir         = qenc_pkg::DIR_REV;
        end
      end
      qenc_pkg::KIND_INIT: begin
        res.state.phase = pins;
      end
      qenc_pkg::KIND_PRESET: begin
        res.state.count = preset;
      end
      default: begin
        res.state = cur;
      end
    endcase
    // out-of-range channel changes nothing and reports zero
    if (!chan_ok) begin
      res.dir = qenc_pkg::DIR_NONE;
    end
    res.position = chan_ok ? res.state.count : '0;
  end

endmodule

FILE: rtl/multi_channel_quadrature_counter.sv
// Multi-channel x4 quadrature counter. Takes one word per clock and returns one result word
// per input word: accepting a word reads the addressed channel's phase and count from the
// registered-read state memory into the s1 stage; from s1 the step is decoded and the new
// state is written back while the output register is loaded. Words to the same channel on
// consecutive cycles are served by forwarding the write-back into the read, so the rate
// stays one word per cycle as long as results are taken. No clearing pass after reset.
module multi_channel_quadrature_counter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [2:0]         channel,
  input  logic               phase_a,
  input  logic               phase_b,
  input  logic signed [31:0] preset_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         channel_out,
  output logic signed [31:0] position,
  output logic signed [1:0]  direction
);

  logic                          in_acc;
  logic                          s1_valid;
  logic                          s1_adv;
  logic [1:0]                    s1_kind;
  logic [2:0]                    s1_channel;
  logic [1:0]                    s1_pins;
  logic [qenc_pkg::COUNT_W-1:0]  s1_preset;
  logic                          s1_ok;
  qenc_pkg::chan_state_t         rd_state;
  qenc_pkg::step_t               step;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign s1_ok    = (int'(s1_channel) < qenc_pkg::NUM_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind    <= kind;
      s1_channel <= channel;
      s1_pins    <= qenc_pkg::phase_of_pins(phase_a, phase_b);
      s1_preset  <= preset_value;
    end
  end

  qenc_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (qenc_pkg::addr_t'(channel)),
    .rd_data (rd_state),
    .wr_en   (s1_adv && step.we),
    .wr_addr (qenc_pkg::addr_t'(s1_channel)),
    .wr_data (step.state)
  );

  qenc_step u_step (
    .kind    (s1_kind),
    .chan_ok (s1_ok),
    .pins    (s1_pins),
    .preset  (s1_preset),
    .cur     (rd_state),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      channel_out <= s1_channel;
      position    <= step.position;
      direction   <= step.dir;
    end
  end

endmodule

FILE: rtl/qenc_checker.sv
// port-level checks for the quadrature counter, bound to the top level
module qenc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         channel_out,
  input logic signed [31:0] position,
  input logic signed [1:0]  direction
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_out) && $stable(position)
      && $stable(direction))
    else $error("result word changed while stalled");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction == qenc_pkg::DIR_NONE) || (direction == qenc_pkg::DIR_FWD)
      || (direction == qenc_pkg::DIR_REV))
    else $error("invalid direction code");

  // a newly raised result traces back to an accepted input word
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without an accepted input word");

  // a full pipe with a stalled output takes no more words
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && $past(in_valid && in_ready) && !$past(rst) |-> !in_ready)
    else $error("input accepted while pipe is full");

endmodule

bind multi_channel_quadrature_counter qenc_checker u_qenc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .channel_out (channel_out),
  .position    (position),
  .direction   (direction)
);
